/* rtl/core/b64d_pkg.sv */
`default_nettype none

package b64d_pkg;

  // Default width of the position and byte counters
  localparam int COUNT_WIDTH = 24;

  // Field widths
  localparam int CHAR_W  = 8;
  localparam int FIELD_W = 24;

  // Character classes beyond the 64 digit values
  localparam logic [7:0] CODE_SKIP = 8'd254;
  localparam logic [7:0] CODE_BAD  = 8'd255;
  localparam logic [7:0] PAD_CHAR  = 8'h3D;

  // Map one character to its digit value, or to the skip / bad class.
  // Both the standard and the URL-safe alphabet are accepted.
  function automatic logic [7:0] decode_char(input logic [7:0] c);
    logic [7:0] code;
    code = CODE_BAD;
    if (c <= 8'h20 || c == 8'hA0) begin
      code = CODE_SKIP;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      code = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      code = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      code = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B || c == 8'h2D) begin
      code = 8'd62;
    end else if (c == 8'h2F || c == 8'h5F) begin
      code = 8'd63;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/b64d_cfg_if.sv */
`default_nettype none

interface b64d_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [b64d_pkg::FIELD_W-1:0] max_output_bytes;

  modport source (output valid, output max_output_bytes, input ready);
  modport sink (input valid, input max_output_bytes, output ready);
endinterface

`default_nettype wire

/* rtl/core/b64d_in_if.sv */
`default_nettype none

interface b64d_in_if;
  logic                        valid;
  logic                        ready;
  logic [b64d_pkg::CHAR_W-1:0] in_char;
  logic                        end_of_stream;

  modport source (output valid, output in_char, output end_of_stream, input ready);
  modport sink (input valid, input in_char, input end_of_stream, output ready);
endinterface

`default_nettype wire

/* rtl/core/b64d_out_if.sv */
`default_nettype none

interface b64d_out_if;
  logic                         valid;
  logic                         ready;
  logic [b64d_pkg::CHAR_W-1:0]  out_byte;
  logic                         is_status;
  logic                         error_found;
  logic [b64d_pkg::FIELD_W-1:0] error_position;
  logic [b64d_pkg::FIELD_W-1:0] byte_count;
  logic                         last;

  modport source (output valid, output out_byte, output is_status, output error_found,
                  output error_position, output byte_count, output last, input ready);
  modport sink (input valid, input out_byte, input is_status, input error_found,
                input error_position, input byte_count, input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/base64_stream_decoder.sv */
// Streaming Base64 decoder.
// chars:   one encoded character per request, end_of_stream on the final one.
// results: decoded bytes, then one status request (error flag, first bad
//          position, byte count) after the final character; last marks the
//          final result caused by each character.
// cfg:     writes the per-stream output byte limit; always ready. Write it
//          only while no results are outstanding.
// The first result of a character is presented the cycle after it
// is accepted. A character that yields results holds the result buffer
// until each has been taken; characters with no result (skipped, or digits
// filling a quad) are taken one per cycle while the buffer is empty. The
// four-entry result buffer is drained one entry per cycle while the
// receiver is ready.
// A new character is accepted in the same cycle the last buffered result is
// taken. When the receiver stalls, the buffer holds and chars.ready drops.
// Reset clears all stream state and empties the buffer; the byte limit
// returns to all ones. Stream state clears as the last character is taken.
`default_nettype none

module base64_stream_decoder #(
  parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  b64d_cfg_if.sink     cfg,
  b64d_in_if.sink      chars,
  b64d_out_if.source   results
);

  localparam int CW = COUNT_WIDTH;
  localparam int FW = b64d_pkg::FIELD_W;
  localparam int LW = (CW > FW) ? CW : FW;
  localparam logic [CW-1:0] CNT_MAX = '1;

  // Configuration and stream state
  logic [FW-1:0] max_bytes;
  logic [17:0]   sextet_buf;
  logic [1:0]    digits;
  logic [CW-1:0] char_pos;
  logic          pad_pending;
  logic [CW-1:0] pad_pos;
  logic [CW-1:0] err_pos;
  logic [CW-1:0] emitted;
  logic          halted;

  // Result buffer
  logic [23:0]   grp;
  logic [1:0]    nbytes;
  logic [FW-1:0] st_err_pos;
  logic [FW-1:0] st_count;
  logic [2:0]    rem;
  logic [1:0]    rd_idx;

  // Next-state values
  logic [17:0]   sextet_buf_next;
  logic [1:0]    digits_next;
  logic [CW-1:0] char_pos_next;
  logic          pad_pending_next;
  logic [CW-1:0] pad_pos_next;
  logic [CW-1:0] err_pos_next;
  logic          halted_next;

  logic [7:0]    code;
  logic          quad;
  logic [23:0]   quad_grp;
  logic          flush;
  logic [23:0]   flush_grp;
  logic [1:0]    want;
  logic [23:0]   grp_next;
  logic [1:0]    n_emit;
  logic [CW-1:0] emitted_next;

  logic [CW:0]   pos_sum;
  logic [CW+1:0] e1_sum;
  logic [CW+1:0] e2_sum;
  logic [CW+1:0] en_sum;
  logic [CW-1:0] e1;
  logic [CW-1:0] e2;
  logic          ok0;
  logic          ok1;
  logic          ok2;

  logic          in_fire;
  logic          out_fire;
  logic          is_data;
  logic [7:0]    sel_byte;
  logic [LW-1:0] err_ext;
  logic [LW-1:0] cnt_ext;

  assign in_fire  = chars.valid && chars.ready;
  assign out_fire = results.valid && results.ready;
  assign cfg.ready = 1'b1;
  assign chars.ready = (rem == 3'd0) || (rem == 3'd1 && results.ready);

  // Saturating position and byte-count increments
  assign pos_sum = {1'b0, char_pos} + {{CW{1'b0}}, 1'b1};
  assign char_pos_next = pos_sum[CW] ? CNT_MAX : pos_sum[CW-1:0];
  assign e1_sum = {2'b00, emitted} + (CW+2)'(1);
  assign e2_sum = {2'b00, emitted} + (CW+2)'(2);
  assign e1 = (|e1_sum[CW+1:CW]) ? CNT_MAX : e1_sum[CW-1:0];
  assign e2 = (|e2_sum[CW+1:CW]) ? CNT_MAX : e2_sum[CW-1:0];

  // Limit checks for up to three bytes
  assign ok0 = LW'(emitted) < LW'(max_bytes);
  assign ok1 = LW'(e1) < LW'(max_bytes);
  assign ok2 = LW'(e2) < LW'(max_bytes);

  assign code = b64d_pkg::decode_char(chars.in_char);

  // Per-character decode step
  always_comb begin
    sextet_buf_next  = sextet_buf;
    digits_next      = digits;
    pad_pending_next = pad_pending;
    pad_pos_next     = pad_pos;
    err_pos_next     = err_pos;
    halted_next      = halted;
    quad             = 1'b0;
    quad_grp         = {sextet_buf, code[5:0]};
    if (!halted && ok0) begin
      if (chars.in_char == b64d_pkg::PAD_CHAR) begin
        if (!pad_pending) begin
          pad_pending_next = 1'b1;
          pad_pos_next     = char_pos_next;
        end
      end else if (code != b64d_pkg::CODE_SKIP) begin
        // padding followed by more input: the first '=' is illegal
        if (pad_pending) begin
          if (err_pos_next == '0) err_pos_next = pad_pos;
          pad_pending_next = 1'b0;
        end
        if (code == b64d_pkg::CODE_BAD) begin
          if (err_pos_next == '0) err_pos_next = char_pos_next;
        end else if (digits == 2'd3) begin
          quad            = 1'b1;
          sextet_buf_next = '0;
          digits_next     = 2'd0;
          if (err_pos_next != '0) halted_next = 1'b1;
        end else begin
          sextet_buf_next = {sextet_buf[11:0], code[5:0]};
          digits_next     = digits + 2'd1;
        end
      end
    end
  end

  // End-of-stream flush of a partial quad, or of a stream with an error
  assign flush = chars.end_of_stream && !halted_next &&
                 (digits_next != 2'd0 || err_pos_next != '0);

  always_comb begin
    unique case (digits_next)
      2'd0:    flush_grp = 24'd0;
      2'd1:    flush_grp = {sextet_buf_next[5:0], 18'd0};
      2'd2:    flush_grp = {sextet_buf_next[11:0], 12'd0};
      default: flush_grp = {sextet_buf_next, 6'd0};
    endcase
  end

  always_comb begin
    want = 2'd0;
    if (quad) begin
      want = 2'd3;
    end else if (flush) begin
      want = (digits_next == 2'd3) ? 2'd2 : 2'd1;
    end
  end

  assign grp_next = quad ? quad_grp : flush_grp;
  assign n_emit = 2'((want > 2'd0 && ok0) ? 1 : 0) + 2'((want > 2'd1 && ok1) ? 1 : 0)
                + 2'((want > 2'd2 && ok2) ? 1 : 0);
  assign en_sum = {2'b00, emitted} + {{CW{1'b0}}, n_emit};
  assign emitted_next = (|en_sum[CW+1:CW]) ? CNT_MAX : en_sum[CW-1:0];
  assign err_ext = LW'(err_pos_next);
  assign cnt_ext = LW'(emitted_next);

  // State and result buffer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes   <= '1;
      sextet_buf  <= '0;
      digits      <= '0;
      char_pos    <= '0;
      pad_pending <= 1'b0;
      pad_pos     <= '0;
      err_pos     <= '0;
      emitted     <= '0;
      halted      <= 1'b0;
      rem         <= '0;
      rd_idx      <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        max_bytes <= cfg.max_output_bytes;
      end
      // a new character reloads the buffer, even as its last entry drains
      if (in_fire) begin
        rem    <= {1'b0, n_emit} + {2'b00, chars.end_of_stream};
        rd_idx <= '0;
        if (chars.end_of_stream) begin
          sextet_buf  <= '0;
          digits      <= '0;
          char_pos    <= '0;
          pad_pending <= 1'b0;
          pad_pos     <= '0;
          err_pos     <= '0;
          emitted     <= '0;
          halted      <= 1'b0;
        end else begin
          sextet_buf  <= sextet_buf_next;
          digits      <= digits_next;
          char_pos    <= char_pos_next;
          pad_pending <= pad_pending_next;
          pad_pos     <= pad_pos_next;
          err_pos     <= err_pos_next;
          emitted     <= emitted_next;
          halted      <= halted_next;
        end
      end else if (out_fire) begin
        rem    <= rem - 3'd1;
        rd_idx <= rd_idx + 2'd1;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      grp        <= grp_next;
      nbytes     <= n_emit;
      st_err_pos <= err_ext[FW-1:0];
      st_count   <= cnt_ext[FW-1:0];
    end
  end

  // Output selection
  always_comb begin
    unique case (rd_idx)
      2'd0:    sel_byte = grp[23:16];
      2'd1:    sel_byte = grp[15:8];
      default: sel_byte = grp[7:0];
    endcase
  end

  assign is_data                = rd_idx < nbytes;
  assign results.valid          = rem != 3'd0;
  assign results.out_byte       = is_data ? sel_byte : 8'd0;
  assign results.is_status      = !is_data;
  assign results.error_found    = !is_data && (st_err_pos != '0);
  assign results.error_position = is_data ? '0 : st_err_pos;
  assign results.byte_count     = is_data ? '0 : st_count;
  assign results.last           = rem == 3'd1;

endmodule

`default_nettype wire
